@@ design/dh_forward_kinematics_chain_defines.svh @@
`ifndef DH_FORWARD_KINEMATICS_CHAIN_DEFINES_SVH
`define DH_FORWARD_KINEMATICS_CHAIN_DEFINES_SVH

// same-cycle implication
`define DHFK_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DHFK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/dhfk_pkg.sv @@
package dhfk_pkg;

   localparam int MUL_W = 34;
   typedef logic signed [MUL_W-1:0] mul_opnd_type;

   localparam logic [16:0] FULL_TURN     = 17'd46080;
   localparam logic [16:0] THREE_QUARTER = 17'd34560;
   localparam logic [16:0] HALF_TURN     = 17'd23040;
   localparam logic [16:0] QUARTER_TURN  = 17'd11520;
   localparam logic [16:0] EIGHTH_TURN   = 17'd5760;

   localparam logic [63:0] PI_Q32  = 64'd13493037705;
   localparam logic [19:0] X_QUO   = 20'(PI_Q32 / 64'd23040);
   localparam logic [14:0] X_REM   = 15'(PI_Q32 % 64'd23040);
   localparam logic [26:0] X_BIAS  = 27'd11520;
   localparam logic [17:0] X_RECIP = 18'(((64'd1 << 23) + 64'd44) / 64'd45);

   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

   // ceil(2^(32+l)/c) with 2^(l-1) < c <= 2^l
   localparam logic [32:0] RECIP_72 = 33'(((64'd1 << 39) + 64'd71) / 64'd72);
   localparam logic [32:0] RECIP_42 = 33'(((64'd1 << 38) + 64'd41) / 64'd42);
   localparam logic [32:0] RECIP_20 = 33'(((64'd1 << 37) + 64'd19) / 64'd20);
   localparam logic [32:0] RECIP_6  = 33'(((64'd1 << 35) + 64'd5) / 64'd6);
   localparam logic [32:0] RECIP_90 = 33'(((64'd1 << 39) + 64'd89) / 64'd90);
   localparam logic [32:0] RECIP_56 = 33'(((64'd1 << 38) + 64'd55) / 64'd56);
   localparam logic [32:0] RECIP_30 = 33'(((64'd1 << 37) + 64'd29) / 64'd30);
   localparam logic [32:0] RECIP_12 = 33'(((64'd1 << 36) + 64'd11) / 64'd12);

endpackage

@@ design/dh_forward_kinematics_chain.sv @@
// req_ready returns once the joint of an accepted transaction is done; on the
//    last joint of a chain rsp_valid rises in that same cycle, or later while an
//    earlier result still waits for rsp_ready
// joints run one at a time, each through the single shared 34x34 multiplier
//    (56 steps per joint, 54 of them use a product)
// reset: synchronous, clears the running point, joint count and all handshakes
`include "dh_forward_kinematics_chain_defines.svh"

module dh_forward_kinematics_chain #(
   parameter int NUM_JOINTS     = 6,
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_joint_angle,
   input  logic signed [31:0] req_link_length,
   input  logic signed [31:0] req_link_offset,
   input  logic signed [15:0] req_link_twist,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_end_x,
   output logic signed [31:0] rsp_end_y,
   output logic signed [31:0] rsp_end_z
);
   import dhfk_pkg::*;

   localparam int F  = TRIG_FRAC_BITS;
   localparam int TW = F + 2;
   localparam int AW = F + 36;
   localparam int PW = 2 * MUL_W;
   localparam int CW = $clog2(NUM_JOINTS + 1);

   localparam logic signed [PW-1:0] PROD_HALF = PW'(1) << (F - 1);
   localparam logic signed [AW-1:0] ACC_HALF  = AW'(1) << (F - 1);
   localparam logic signed [AW-1:0] SAT_HI    = AW'(64'sh7fff_ffff);
   localparam logic signed [AW-1:0] SAT_LO    = AW'(-64'sh8000_0000);

   localparam logic [5:0] S_PREP = 6'd0;
   localparam logic [5:0] S_XLO  = 6'd1;
   localparam logic [5:0] S_XQ   = 6'd2;
   localparam logic [5:0] S_XHI  = 6'd3;
   localparam logic [5:0] S_SQ   = 6'd4;
   localparam logic [5:0] S_D72  = 6'd5;
   localparam logic [5:0] S_M1   = 6'd6;
   localparam logic [5:0] S_D42  = 6'd7;
   localparam logic [5:0] S_M2   = 6'd8;
   localparam logic [5:0] S_D20  = 6'd9;
   localparam logic [5:0] S_M3   = 6'd10;
   localparam logic [5:0] S_D6   = 6'd11;
   localparam logic [5:0] S_SINF = 6'd12;
   localparam logic [5:0] S_D90  = 6'd13;
   localparam logic [5:0] S_M4   = 6'd14;
   localparam logic [5:0] S_D56  = 6'd15;
   localparam logic [5:0] S_M5   = 6'd16;
   localparam logic [5:0] S_D30  = 6'd17;
   localparam logic [5:0] S_M6   = 6'd18;
   localparam logic [5:0] S_D12  = 6'd19;
   localparam logic [5:0] S_COSF = 6'd20;
   localparam logic [5:0] S_SC   = 6'd21;
   localparam logic [5:0] S_SS   = 6'd22;
   localparam logic [5:0] S_CC   = 6'd23;
   localparam logic [5:0] S_CS   = 6'd24;
   localparam logic [5:0] S_X0   = 6'd25;
   localparam logic [5:0] S_X1   = 6'd26;
   localparam logic [5:0] S_X2   = 6'd27;
   localparam logic [5:0] S_X3   = 6'd28;
   localparam logic [5:0] S_Y0   = 6'd29;
   localparam logic [5:0] S_Y1   = 6'd30;
   localparam logic [5:0] S_Y2   = 6'd31;
   localparam logic [5:0] S_Y3   = 6'd32;
   localparam logic [5:0] S_Z0   = 6'd33;
   localparam logic [5:0] S_Z1   = 6'd34;

   function automatic logic [F:0] to_trig(input logic [32:0] v);
      logic [33:0] s;
      s = {1'b0, v} + (34'd1 << (31 - F));
      return (F + 1)'(s >> (32 - F));
   endfunction

   logic                 busy_ff, busy_in;
   logic                 phase_ff, phase_in;
   logic                 ang_sel_ff, ang_sel_in;
   logic [5:0]           step_ff, step_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic signed [15:0]   th_ff, th_in, al_ff, al_in;
   logic signed [31:0]   a_ff, a_in, d_ff, d_in;
   logic [12:0]          u_ff, u_in;
   logic [1:0]           q_ff, q_in;
   logic                 swap_ff, swap_in;
   logic [31:0]          x_ff, x_in, x2_ff, x2_in;
   logic [32:0]          t_ff, t_in;
   logic [F:0]           sraw_ff, sraw_in;
   logic signed [TW-1:0] st_ff, st_in, ct_ff, ct_in, sa_ff, sa_in, ca_ff, ca_in;
   logic signed [TW-1:0] sc_ff, sc_in, ss_ff, ss_in, cc_ff, cc_in, cs_ff, cs_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [31:0]   nx_ff, nx_in, ny_ff, ny_in;
   logic signed [31:0]   px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;

   mul_opnd_type         mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   logic [PW-2:0]        prod_u;
   logic [32:0]          div_recip;
   logic [5:0]           div_sh;
   logic [32:0]          t_div;
   logic signed [15:0]   raw_ang;
   logic [17:0]          amod_ext;
   logic [16:0]          amod;
   logic [13:0]          rq;
   logic [1:0]           q_sel;
   logic [32:0]          cos_q32;
   logic [F:0]           sin_v, cos_v, s0, c0;
   logic signed [TW-1:0] s0s, c0s, s_map, c_map;
   logic signed [PW-1:0] prod_rnd;
   logic signed [AW-1:0] acc_base, acc_term, acc_sum, acc_rnd;
   logic                 acc_neg;
   logic signed [31:0]   coord_sat;
   logic                 last_joint, out_block, accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_end_x = rsp_x_ff;
   assign rsp_end_y = rsp_y_ff;
   assign rsp_end_z = rsp_z_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         S_XLO: begin
            mul_a = MUL_W'(u_ff);
            mul_b = MUL_W'(X_REM);
         end
         S_XQ: begin
            mul_a = MUL_W'(t_ff);
            mul_b = MUL_W'(X_RECIP);
         end
         S_XHI: begin
            mul_a = MUL_W'(u_ff);
            mul_b = MUL_W'(X_QUO);
         end
         S_SQ: begin
            mul_a = MUL_W'(x_ff);
            mul_b = MUL_W'(x_ff);
         end
         S_D72, S_D42, S_D20, S_D6, S_D90, S_D56, S_D30, S_D12: begin
            mul_a = MUL_W'(t_ff);
            mul_b = MUL_W'(div_recip);
         end
         S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_COSF: begin
            mul_a = MUL_W'(x2_ff);
            mul_b = MUL_W'(t_ff);
         end
         S_SINF: begin
            mul_a = MUL_W'(x_ff);
            mul_b = MUL_W'(t_ff);
         end
         S_SC: begin mul_a = MUL_W'(st_ff); mul_b = MUL_W'(ca_ff); end
         S_SS: begin mul_a = MUL_W'(st_ff); mul_b = MUL_W'(sa_ff); end
         S_CC: begin mul_a = MUL_W'(ct_ff); mul_b = MUL_W'(ca_ff); end
         S_CS: begin mul_a = MUL_W'(ct_ff); mul_b = MUL_W'(sa_ff); end
         S_X0: begin mul_a = MUL_W'(ct_ff); mul_b = MUL_W'(px_ff); end
         S_X1: begin mul_a = MUL_W'(sc_ff); mul_b = MUL_W'(py_ff); end
         S_X2: begin mul_a = MUL_W'(ss_ff); mul_b = MUL_W'(pz_ff); end
         S_X3: begin mul_a = MUL_W'(a_ff);  mul_b = MUL_W'(ct_ff); end
         S_Y0: begin mul_a = MUL_W'(st_ff); mul_b = MUL_W'(px_ff); end
         S_Y1: begin mul_a = MUL_W'(cc_ff); mul_b = MUL_W'(py_ff); end
         S_Y2: begin mul_a = MUL_W'(cs_ff); mul_b = MUL_W'(pz_ff); end
         S_Y3: begin mul_a = MUL_W'(a_ff);  mul_b = MUL_W'(st_ff); end
         S_Z0: begin mul_a = MUL_W'(sa_ff); mul_b = MUL_W'(py_ff); end
         S_Z1: begin mul_a = MUL_W'(ca_ff); mul_b = MUL_W'(pz_ff); end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // reciprocal and shift for the series divide steps
   always_comb begin
      unique case (step_ff)
         S_D42:   begin div_recip = RECIP_42; div_sh = 6'd38; end
         S_D20:   begin div_recip = RECIP_20; div_sh = 6'd37; end
         S_D6:    begin div_recip = RECIP_6;  div_sh = 6'd35; end
         S_D90:   begin div_recip = RECIP_90; div_sh = 6'd39; end
         S_D56:   begin div_recip = RECIP_56; div_sh = 6'd38; end
         S_D30:   begin div_recip = RECIP_30; div_sh = 6'd37; end
         S_D12:   begin div_recip = RECIP_12; div_sh = 6'd36; end
         default: begin div_recip = RECIP_72; div_sh = 6'd39; end
      endcase
   end

   assign prod_u = prod_ff[PW-2:0];
   assign t_div  = ONE_Q32 - 33'(prod_u >> div_sh);

   // angle reduction to an octant
   assign raw_ang  = ang_sel_ff ? al_ff : th_ff;
   assign amod_ext = 18'(raw_ang) + 18'(FULL_TURN);
   assign amod     = (amod_ext >= 18'(FULL_TURN)) ? 17'(amod_ext - 18'(FULL_TURN))
                                                  : amod_ext[16:0];
   always_comb begin
      priority if (amod >= THREE_QUARTER) begin
         q_sel = 2'd3;
         rq    = 14'(amod - THREE_QUARTER);
      end else if (amod >= HALF_TURN) begin
         q_sel = 2'd2;
         rq    = 14'(amod - HALF_TURN);
      end else if (amod >= QUARTER_TURN) begin
         q_sel = 2'd1;
         rq    = 14'(amod - QUARTER_TURN);
      end else begin
         q_sel = 2'd0;
         rq    = 14'(amod);
      end
   end

   // octant and quadrant mapping of the series results
   assign cos_q32 = ONE_Q32 - {2'b00, prod_ff[63:33]};
   assign sin_v   = to_trig({1'b0, prod_ff[63:32]});
   assign cos_v   = to_trig(cos_q32);
   assign s0      = swap_ff ? cos_v : sraw_ff;
   assign c0      = swap_ff ? sraw_ff : cos_v;
   assign s0s     = $signed({1'b0, s0});
   assign c0s     = $signed({1'b0, c0});

   always_comb begin
      unique case (q_ff)
         2'd0:    begin s_map = s0s;  c_map = c0s;  end
         2'd1:    begin s_map = c0s;  c_map = -s0s; end
         2'd2:    begin s_map = -s0s; c_map = -c0s; end
         default: begin s_map = -c0s; c_map = s0s;  end
      endcase
   end

   assign prod_rnd = (prod_ff + PROD_HALF) >>> F;

   // coordinate accumulation
   assign acc_term = AW'(prod_ff);
   assign acc_neg  = (step_ff == S_X1) || (step_ff == S_Y2);
   always_comb begin
      priority if ((step_ff == S_X0) || (step_ff == S_Y0)) begin
         acc_base = '0;
      end else if (step_ff == S_Z0) begin
         acc_base = AW'(d_ff) <<< F;
      end else begin
         acc_base = acc_ff;
      end
   end
   assign acc_sum = acc_neg ? (acc_base - acc_term) : (acc_base + acc_term);
   assign acc_rnd = (acc_sum + ACC_HALF) >>> F;
   always_comb begin
      priority if (acc_rnd > SAT_HI) begin
         coord_sat = 32'sh7fff_ffff;
      end else if (acc_rnd < SAT_LO) begin
         coord_sat = -32'sh8000_0000;
      end else begin
         coord_sat = 32'(acc_rnd);
      end
   end

   assign last_joint = (cnt_ff == CW'(NUM_JOINTS - 1));
   assign out_block  = rsp_valid_ff && !rsp_ready;

   always_comb begin
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      ang_sel_in   = ang_sel_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      th_in        = th_ff;
      al_in        = al_ff;
      a_in         = a_ff;
      d_in         = d_ff;
      u_in         = u_ff;
      q_in         = q_ff;
      swap_in      = swap_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      t_in         = t_ff;
      sraw_in      = sraw_ff;
      st_in        = st_ff;
      ct_in        = ct_ff;
      sa_in        = sa_ff;
      ca_in        = ca_ff;
      sc_in        = sc_ff;
      ss_in        = ss_ff;
      cc_in        = cc_ff;
      cs_in        = cs_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;

      if (accept) begin
         busy_in    = 1'b1;
         phase_in   = 1'b0;
         ang_sel_in = 1'b0;
         step_in    = S_PREP;
         th_in      = req_joint_angle;
         al_in      = req_link_twist;
         a_in       = req_link_length;
         d_in       = req_link_offset;
      end else if (busy_ff && !phase_ff) begin
         prod_in  = mul_p;
         phase_in = 1'b1;
      end else if (busy_ff) begin
         phase_in = 1'b0;
         step_in  = step_ff + 6'd1;
         unique case (step_ff)
            S_PREP: begin
               q_in    = q_sel;
               swap_in = rq > 14'(EIGHTH_TURN);
               u_in    = (rq <= 14'(EIGHTH_TURN)) ? 13'(rq) : 13'(14'(QUARTER_TURN) - rq);
            end
            S_XLO: t_in  = 33'((prod_u[26:0] + X_BIAS) >> 9);
            S_XQ:  x2_in = 32'(prod_u >> 23);
            S_XHI: x_in  = prod_u[31:0] + x2_ff;
            S_SQ: begin
               x2_in = prod_u[63:32];
               t_in  = {1'b0, prod_u[63:32]};
            end
            S_D72, S_D42, S_D20, S_D6, S_D90, S_D56, S_D30, S_D12: t_in = t_div;
            S_M1, S_M2, S_M3, S_M4, S_M5, S_M6: t_in = {1'b0, prod_u[63:32]};
            S_SINF: begin
               sraw_in = sin_v;
               t_in    = {1'b0, x2_ff};
            end
            S_COSF: begin
               if (!ang_sel_ff) begin
                  st_in      = s_map;
                  ct_in      = c_map;
                  ang_sel_in = 1'b1;
                  step_in    = S_PREP;
               end else begin
                  sa_in   = s_map;
                  ca_in   = c_map;
                  step_in = S_SC;
               end
            end
            S_SC: sc_in = TW'(prod_rnd);
            S_SS: ss_in = TW'(prod_rnd);
            S_CC: cc_in = TW'(prod_rnd);
            S_CS: cs_in = TW'(prod_rnd);
            S_X0, S_X1, S_X2, S_Y0, S_Y1, S_Y2, S_Z0: acc_in = acc_sum;
            S_X3: nx_in = coord_sat;
            S_Y3: ny_in = coord_sat;
            S_Z1: begin
               if (last_joint && out_block) begin
                  phase_in = 1'b1;
                  step_in  = step_ff;
               end else if (last_joint) begin
                  busy_in      = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = nx_ff;
                  rsp_y_in     = ny_ff;
                  rsp_z_in     = coord_sat;
                  px_in        = '0;
                  py_in        = '0;
                  pz_in        = '0;
                  cnt_in       = '0;
               end else begin
                  busy_in = 1'b0;
                  px_in   = nx_ff;
                  py_in   = ny_ff;
                  pz_in   = coord_sat;
                  cnt_in  = cnt_ff + CW'(1);
               end
            end
            default: step_in = S_PREP;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         ang_sel_ff   <= 1'b0;
         step_ff      <= S_PREP;
         cnt_ff       <= '0;
         px_ff        <= '0;
         py_ff        <= '0;
         pz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         ang_sel_ff   <= ang_sel_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         px_ff        <= px_in;
         py_ff        <= py_in;
         pz_ff        <= pz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      th_ff    <= th_in;
      al_ff    <= al_in;
      a_ff     <= a_in;
      d_ff     <= d_in;
      u_ff     <= u_in;
      q_ff     <= q_in;
      swap_ff  <= swap_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      t_ff     <= t_in;
      sraw_ff  <= sraw_in;
      st_ff    <= st_in;
      ct_ff    <= ct_in;
      sa_ff    <= sa_in;
      ca_ff    <= ca_in;
      sc_ff    <= sc_in;
      ss_ff    <= ss_in;
      cc_ff    <= cc_in;
      cs_ff    <= cs_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_z_ff <= rsp_z_in;
   end

   `DHFK_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, busy_ff && step_ff == S_PREP && !ang_sel_ff && !phase_ff, "accepted transaction did not start a joint")
   `DHFK_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, cnt_ff < CW'(NUM_JOINTS), "joint count out of range")
   `DHFK_ASSERT_IMPLY(a_kin_after_trig, clock, reset, busy_ff && step_ff >= S_SC, ang_sel_ff, "kinematics before both angles done")
   `DHFK_ASSERT_NEXT(a_emit_restart, clock, reset, busy_ff && phase_ff && step_ff == S_Z1 && last_joint && !out_block, rsp_valid_ff && cnt_ff == '0 && px_ff == '0 && !busy_ff, "chain end did not emit and restart")

endmodule
